// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, reporting through $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/lkvc_pkg.sv =====
// ----------------------------------------------------------------------------
// lkvc_pkg
// Types, constants and helpers shared by the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int unsigned LKVC_ENTRIES  = 16;
   localparam int unsigned DATA_W        = 32;
   localparam int unsigned CAP_W         = 5;
   localparam int unsigned CAP_RESET_RAW = 16;

   // Value returned by a get that misses
   localparam logic [DATA_W-1:0] MISS_VALUE = '1;

   typedef enum logic {
      CMD_GET = 1'b0,
      CMD_PUT = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                  cmd;
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] write_value;
   } req_type;

   typedef struct packed {
      logic                     hit;
      logic signed [DATA_W-1:0] read_value;
      logic                     evicted;
      logic signed [DATA_W-1:0] evicted_key;
   } rsp_type;

   // Clamp a capacity write to the number of slots
   function automatic logic [CAP_W-1:0] sat_cap(input logic [CAP_W-1:0] raw,
                                                input int unsigned limit);
      logic [CAP_W-1:0] res;
      res = raw;
      if (int'(raw) > int'(limit)) begin
         res = CAP_W'(limit);
      end
      return res;
   endfunction

endpackage

// ===== design/lkvc_store.sv =====
// ----------------------------------------------------------------------------
// lkvc_store
// Entry storage with parallel key match, recency ranks and LRU replacement.
// Result is combinational from the registered operation; state updates at
// the end of the same cycle.
// ----------------------------------------------------------------------------
module lkvc_store
   import lkvc_pkg::*;
#(
   parameter int unsigned ENTRIES = LKVC_ENTRIES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             op_valid,
   input  req_type          op,
   input  logic [CAP_W-1:0] cap,
   output rsp_type          rsp
);

   localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
   localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   // Entry state
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0]   rank_ff  [ENTRIES];
   logic [IDX_W-1:0]   rank_in  [ENTRIES];
   logic [DATA_W-1:0]  key_ff   [ENTRIES];
   logic [DATA_W-1:0]  value_ff [ENTRIES];
   logic [CNT_W-1:0]   count_ff, count_in;

   // Lookup and recency terms
   logic [ENTRIES-1:0] match, lru_pre, lru_post, drop_oh, avail, free_oh;
   logic [ENTRIES-1:0] ins_oh, val_we;
   logic [IDX_W-1:0]   t_rank [ENTRIES];
   logic [IDX_W-1:0]   hit_rank, last_rank;
   logic [DATA_W-1:0]  hit_value, lru_pre_key, lru_post_key;
   logic               hit, over, full, empty;
   logic [CMP_W-1:0]   cnt_c, cap_c;

   assign cnt_c     = CMP_W'(count_ff);
   assign cap_c     = CMP_W'(cap);
   assign over      = cnt_c > cap_c;
   assign full      = cnt_c >= cap_c;
   assign empty     = (count_ff == '0);
   assign last_rank = IDX_W'(count_ff - CNT_W'(1));

   // Parallel key compare; at most one entry matches
   always_comb begin
      hit_rank  = '0;
      hit_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = valid_ff[i] && (key_ff[i] == op.key);
         if (match[i]) begin
            hit_rank  = hit_rank | rank_ff[i];
            hit_value = hit_value | value_ff[i];
         end
      end
      hit = |match;
   end

   // Ranks after touching the hit entry, and LRU before and after the touch
   always_comb begin
      lru_pre_key  = '0;
      lru_post_key = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (match[i]) begin
            t_rank[i] = '0;
         end else if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
            t_rank[i] = rank_ff[i] + IDX_W'(1);
         end else begin
            t_rank[i] = rank_ff[i];
         end
         lru_pre[i]  = valid_ff[i] && (rank_ff[i] == last_rank);
         lru_post[i] = valid_ff[i] && (t_rank[i] == last_rank);
         if (lru_pre[i]) begin
            lru_pre_key = lru_pre_key | key_ff[i];
         end
         if (lru_post[i]) begin
            lru_post_key = lru_post_key | key_ff[i];
         end
      end
   end

   // Slot freed by an insert that evicts, then lowest free slot
   assign drop_oh = (op.cmd == CMD_PUT && !hit && full && !empty) ? lru_pre : '0;
   assign avail   = ~(valid_ff & ~drop_oh);
   assign free_oh = avail & (~avail + ENTRIES'(1));

   // Operation decode and next state
   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      rank_in  = rank_ff;
      ins_oh   = '0;
      val_we   = '0;
      rsp      = '0;
      rsp.hit  = hit;
      case (op.cmd)
         CMD_GET: begin
            rsp.read_value = hit ? hit_value : MISS_VALUE;
            if (op_valid && hit) begin
               rank_in = t_rank;
            end
         end
         CMD_PUT: begin
            if (hit) begin
               if (op_valid) begin
                  val_we  = match;
                  rank_in = t_rank;
               end
               if (over) begin
                  rsp.evicted     = 1'b1;
                  rsp.evicted_key = lru_post_key;
                  if (op_valid) begin
                     valid_in = valid_ff & ~lru_post;
                     count_in = count_ff - CNT_W'(1);
                  end
               end
            end else if (full && empty) begin
               // zero capacity and nothing stored: the new key bounces out
               rsp.evicted     = 1'b1;
               rsp.evicted_key = op.key;
            end else begin
               rsp.evicted     = full;
               rsp.evicted_key = full ? lru_pre_key : '0;
               if (op_valid) begin
                  ins_oh   = free_oh;
                  val_we   = free_oh;
                  valid_in = (valid_ff & ~drop_oh) | free_oh;
                  count_in = full ? count_ff : count_ff + CNT_W'(1);
                  for (int i = 0; i < ENTRIES; i++) begin
                     rank_in[i] = free_oh[i] ? '0 : rank_ff[i] + IDX_W'(1);
                  end
               end
            end
         end
         default: begin
            rsp.read_value = MISS_VALUE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   // Entry payload
   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         rank_ff[i] <= rank_in[i];
         if (ins_oh[i]) begin
            key_ff[i] <= op.key;
         end
         if (val_we[i]) begin
            value_ff[i] <= op.write_value;
         end
      end
   end

endmodule

// ===== design/lru_key_value_cache.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value cache with least-recently-used replacement.
//
//   channel  ports                              direction  beat taken when
//   req      start, busy, req_data              in         start && !busy
//   rsp      rsp_valid, rsp_data                out        rsp_valid (1 cycle)
//   csr      csr_valid, csr_ready, csr_wdata    in         csr_valid && csr_ready
//
// One item per cycle. A request is registered, looked up and applied in the
// next cycle, and its result is registered into rsp_data. The lookup cycle
// holds the 32-bit key compare over all slots and the rank update. Reset
// clears the valid bits and occupancy at once; there is no clearing pass.
// busy stays low and the receiver cannot stall.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lru_key_value_cache
   import lkvc_pkg::*;
#(
   parameter int unsigned ENTRIES = LKVC_ENTRIES
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   // response channel
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   // capacity register
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CAP_W-1:0] csr_wdata
);

   localparam logic [CAP_W-1:0] CAP_RESET = sat_cap(CAP_W'(CAP_RESET_RAW), ENTRIES);

   logic             req_valid_ff;
   req_type          req_ff;
   logic [CAP_W-1:0] cap_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;
   rsp_type          store_rsp;
   logic             req_take;

   // Store never stalls a request or a register write
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign req_take  = start && !busy;

   // Capacity register, clamped to the slot count
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         cap_ff <= sat_cap(csr_wdata, ENTRIES);
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_take;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
   end

   lkvc_store #(
      .ENTRIES (ENTRIES)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .op_valid (req_valid_ff),
      .op       (req_ff),
      .cap      (cap_ff),
      .rsp      (store_rsp)
   );

   // Result register: one strobe per beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_ff <= store_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   `ASSERT_NEXT(a_rsp_follows_req, clock, reset, req_valid_ff, rsp_valid_ff, "request without result beat")
   `ASSERT_IMPLIES(a_get_no_evict, clock, reset, rsp_valid_ff && $past(req_ff.cmd) == CMD_GET, !rsp_ff.evicted && rsp_ff.evicted_key == '0, "get reported an eviction")
   `ASSERT_HOLDS(a_cap_clamped, clock, reset, int'(cap_ff) <= int'(ENTRIES), "capacity above slot count")

endmodule

// ===== dv/lru_cache_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_cache_checker
// Watches the request, response and capacity channels of the LRU key/value
// cache. It keeps its own copy of the slots and recency order, predicts each
// response beat as requests are taken, and compares field by field in order.
// ----------------------------------------------------------------------------
module lru_cache_checker
   import lkvc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  req_type          req_data,
   input  logic             rsp_valid,
   input  rsp_type          rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [CAP_W-1:0] csr_wdata,
   output int               fail_count,
   output int               expected_count,
   output int               rsp_count,
   output int               hit_count,
   output int               evict_count,
   output int               cfg_count
);

   // Shadow of the cache contents; rank 0 is most recent
   logic              slot_used [LKVC_ENTRIES];
   logic [DATA_W-1:0] slot_key  [LKVC_ENTRIES];
   logic [DATA_W-1:0] slot_val  [LKVC_ENTRIES];
   int unsigned       slot_rank [LKVC_ENTRIES];
   int unsigned       live_count;
   int unsigned       cap_limit;

   rsp_type           predicted_rsp [$];

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= 25) begin
         $display("[%0t] checker: %s", $realtime, msg);
      end
   endtask

   function automatic int find_slot(input logic [DATA_W-1:0] k);
      for (int i = 0; i < LKVC_ENTRIES; i++) begin
         if (slot_used[i] && slot_key[i] == k) return i;
      end
      return -1;
   endfunction

   function automatic int oldest_slot();
      for (int i = 0; i < LKVC_ENTRIES; i++) begin
         if (slot_used[i] && slot_rank[i] + 1 == live_count) return i;
      end
      return -1;
   endfunction

   function automatic int free_slot();
      for (int i = 0; i < LKVC_ENTRIES; i++) begin
         if (!slot_used[i]) return i;
      end
      return -1;
   endfunction

   // Move a slot to the front, ageing everything that was ahead of it
   function automatic void promote(input int s);
      int unsigned r;
      r = slot_rank[s];
      for (int i = 0; i < LKVC_ENTRIES; i++) begin
         if (slot_used[i] && slot_rank[i] < r) slot_rank[i]++;
      end
      slot_rank[s] = 0;
   endfunction

   // Drop a slot and close the gap it leaves in the order
   function automatic void retire(input int s);
      int unsigned r;
      r = slot_rank[s];
      slot_used[s] = 1'b0;
      for (int i = 0; i < LKVC_ENTRIES; i++) begin
         if (slot_used[i] && slot_rank[i] > r) slot_rank[i]--;
      end
      live_count--;
   endfunction

   function automatic void insert(input int s, input logic [DATA_W-1:0] k,
                                  input logic [DATA_W-1:0] v);
      for (int i = 0; i < LKVC_ENTRIES; i++) begin
         if (slot_used[i]) slot_rank[i]++;
      end
      slot_used[s] = 1'b1;
      slot_key[s]  = k;
      slot_val[s]  = v;
      slot_rank[s] = 0;
      live_count++;
   endfunction

   // Apply one request to the shadow and return the response it should give
   function automatic rsp_type apply_access(input req_type rq);
      rsp_type r;
      int      s;
      int      victim;
      r     = '0;
      s     = find_slot(rq.key);
      r.hit = (s >= 0);
      if (rq.cmd == CMD_GET) begin
         if (s >= 0) begin
            promote(s);
            r.read_value = slot_val[s];
         end else begin
            r.read_value = MISS_VALUE;
         end
      end else if (s >= 0) begin
         // refresh first, then trim if over the limit (may drop itself)
         slot_val[s] = rq.write_value;
         promote(s);
         if (live_count > cap_limit) begin
            victim = oldest_slot();
            if (victim >= 0) begin
               r.evicted     = 1'b1;
               r.evicted_key = slot_key[victim];
               retire(victim);
            end
         end
      end else begin
         if (live_count >= cap_limit) begin
            if (live_count == 0) begin
               // zero capacity, empty store: the new key bounces straight out
               r.evicted     = 1'b1;
               r.evicted_key = rq.key;
            end else begin
               victim = oldest_slot();
               if (victim >= 0) begin
                  r.evicted     = 1'b1;
                  r.evicted_key = slot_key[victim];
                  retire(victim);
               end
            end
         end
         if (!(cap_limit == 0 && r.evicted && r.evicted_key == rq.key
               && live_count == 0)) begin
            s = free_slot();
            if (s >= 0) insert(s, rq.key, rq.write_value);
         end
      end
      return r;
   endfunction

   // Sample all channels on the rising edge, before the drivers update
   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < LKVC_ENTRIES; i++) begin
            slot_used[i] = 1'b0;
            slot_key[i]  = '0;
            slot_val[i]  = '0;
            slot_rank[i] = 0;
         end
         live_count = 0;
         cap_limit  = LKVC_ENTRIES;
         predicted_rsp.delete();
         fail_count  = 0;
         rsp_count   = 0;
         hit_count   = 0;
         evict_count = 0;
         cfg_count   = 0;
      end else begin
         // capacity write, saturating at the slot count
         if (csr_valid && csr_ready) begin
            cap_limit = (csr_wdata > LKVC_ENTRIES) ? LKVC_ENTRIES : csr_wdata;
            cfg_count++;
         end
         // response beat against the oldest prediction
         if (rsp_valid) begin
            if (predicted_rsp.size() == 0) begin
               note_failure($sformatf("response beat with nothing pending: %p",
                                      rsp_data));
            end else begin
               want = predicted_rsp.pop_front();
               rsp_count++;
               if (want.hit) hit_count++;
               if (want.evicted) evict_count++;
               if (rsp_data.hit !== want.hit)
                  note_failure($sformatf("beat %0d hit %b, want %b",
                                         rsp_count, rsp_data.hit, want.hit));
               if (rsp_data.read_value !== want.read_value)
                  note_failure($sformatf("beat %0d read_value %h, want %h", rsp_count,
                                         rsp_data.read_value, want.read_value));
               if (rsp_data.evicted !== want.evicted)
                  note_failure($sformatf("beat %0d evicted %b, want %b", rsp_count,
                                         rsp_data.evicted, want.evicted));
               if (rsp_data.evicted_key !== want.evicted_key)
                  note_failure($sformatf("beat %0d evicted_key %h, want %h", rsp_count,
                                         rsp_data.evicted_key, want.evicted_key));
            end
         end
         // request beat
         if (start && !busy) begin
            predicted_rsp.push_back(apply_access(req_data));
         end
      end
      expected_count = predicted_rsp.size();
   end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the LRU key/value cache. A short directed run
// walks the capacity corner cases, then random gets and puts over a small key
// pool run under a series of capacity settings, with random request gaps or in bursts.
// ----------------------------------------------------------------------------
module testbench;
   import lkvc_pkg::*;

   localparam int POOL_SIZE = 24;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_data;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [CAP_W-1:0] csr_wdata;

   int               fail_count;
   int               expected_count;
   int               rsp_count;
   int               hit_count;
   int               evict_count;
   int               cfg_count;

   logic [DATA_W-1:0] key_pool [POOL_SIZE];

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   lru_key_value_cache i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   lru_cache_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .expected_count (expected_count),
      .rsp_count      (rsp_count),
      .hit_count      (hit_count),
      .evict_count    (evict_count),
      .cfg_count      (cfg_count)
   );

   // One request beat; start is left high for a following beat
   task automatic access(input cmd_type c, input logic [DATA_W-1:0] k,
                         input logic [DATA_W-1:0] v);
      req_type rq;
      rq.cmd         = c;
      rq.key         = k;
      rq.write_value = v;
      req_data <= rq;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic pause(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Let every pending response come back, plus a little slack
   task automatic settle();
      start <= 1'b0;
      @(negedge clock);
      while (expected_count != 0) @(negedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] v);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   initial begin
      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_wdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin : stimulus
      int                seg;
      int                span;
      logic              burst;
      logic [CAP_W-1:0]  cap;
      logic [DATA_W-1:0] k;
      cmd_type           c;
      @(negedge clock);
      while (reset) @(negedge clock);
      @(posedge clock);

      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7fff_ffff;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hffff_ffff;
      for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

      // zero capacity on an empty store: the put bounces itself
      write_capacity(0);
      access(CMD_PUT, 32'h8000_0000, 32'h1234_5678);
      access(CMD_GET, 32'h8000_0000, 32'h0);
      settle();

      // single entry, then zero capacity: refreshing it evicts itself
      write_capacity(1);
      access(CMD_PUT, 32'h0000_0007, 32'hdead_beef);
      settle();
      write_capacity(0);
      access(CMD_PUT, 32'h0000_0007, 32'h0bad_cafe);
      settle();

      // above the slot count saturates; extremes, hits, misses, overwrite
      write_capacity(31);
      access(CMD_PUT, 32'h8000_0000, 32'h7fff_ffff);
      access(CMD_PUT, 32'h7fff_ffff, 32'h8000_0000);
      access(CMD_PUT, 32'h0000_0000, 32'hffff_ffff);
      access(CMD_PUT, 32'hffff_ffff, 32'h0000_0000);
      access(CMD_GET, 32'hffff_ffff, 32'h5555_5555);
      access(CMD_GET, 32'h0000_0005, 32'h0);
      access(CMD_PUT, 32'h0000_0000, 32'h0000_0063);
      // fill the store, then one more new key evicts the oldest
      for (int i = 0; i < 12; i++) begin
         access(CMD_PUT, 32'h0000_0100 + i, $urandom);
      end
      access(CMD_PUT, 32'h0000_0200, 32'haaaa_aaaa);
      settle();

      // limit dropped below occupancy: a refreshing put still trims one
      write_capacity(2);
      access(CMD_PUT, 32'h0000_0200, 32'h5555_5555);

      // random segments, each under its own capacity
      for (seg = 0; seg < 11; seg++) begin
         settle();
         case (seg)
            0: cap = 31;
            1: cap = 1;
            2: cap = 0;
            3: cap = 16;
            4: cap = 17;
            5: cap = 3;
            6: cap = 8;
            7: cap = 2;
            default: cap = CAP_W'($urandom_range(0, 31));
         endcase
         write_capacity(cap);
         burst = ($urandom_range(0, 3) == 0);
         span  = $urandom_range(3, POOL_SIZE);
         repeat (120) begin
            c = ($urandom_range(0, 1) == 1) ? CMD_PUT : CMD_GET;
            if ($urandom_range(0, 9) == 0) k = $urandom;
            else k = key_pool[$urandom_range(0, span - 1)];
            access(c, k, $urandom);
            if (!burst) pause(pick_gap());
         end
      end

      settle();
      repeat (4) @(posedge clock);
      $display("run: %0d responses checked, %0d hits, %0d evictions,",
               rsp_count, hit_count, evict_count);
      $display("     %0d capacity writes from 0 up to saturation", cfg_count);
      if (fail_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("testbench: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/lkvc_pkg.sv
design/lkvc_store.sv
design/lru_key_value_cache.sv
dv/lru_cache_checker.sv
dv/testbench.sv
